FILE: design/c2_interface_frame_master_defines.svh
// assertion macros for the c2 interface frame master checker
`ifndef C2_INTERFACE_FRAME_MASTER_DEFINES_SVH
`define C2_INTERFACE_FRAME_MASTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define C2IFM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2ifm same-cycle check failed");

// next-cycle implication, disabled during reset
`define C2IFM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2ifm next-cycle check failed");

`endif

FILE: design/c2ifm_pkg.sv
// types, codes and constants of the c2 interface frame master
package c2ifm_pkg;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_WAR  = 3'd1;
    localparam logic [2:0] OP_RAR  = 3'd2;
    localparam logic [2:0] OP_WDR  = 3'd3;
    localparam logic [2:0] OP_RDR  = 3'd4;
    localparam logic [2:0] OP_RST  = 3'd5;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START  = 4'd1;
    localparam logic [3:0] PH_INS    = 4'd2;
    localparam logic [3:0] PH_LENGTH = 4'd3;
    localparam logic [3:0] PH_DOUT   = 4'd4;
    localparam logic [3:0] PH_DIN    = 4'd5;
    localparam logic [3:0] PH_WAIT   = 4'd6;
    localparam logic [3:0] PH_STOP   = 4'd7;
    localparam logic [3:0] PH_RLOW   = 4'd8;
    localparam logic [3:0] PH_RHIGH  = 4'd9;

    localparam logic [1:0] REG_WAIT_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_RESET_LOW     = 2'd1;
    localparam logic [1:0] REG_RESET_RELEASE = 2'd2;

    localparam logic [15:0] WAIT_TIMEOUT_RST  = 16'd1000;
    localparam logic [15:0] RESET_LOW_RST     = 16'd20;
    localparam logic [15:0] RESET_RELEASE_RST = 16'd2;
    localparam logic [15:0] WAIT_COUNT_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [15:0] wait_timeout_strobes;
        logic [15:0] reset_low_ticks;
        logic [15:0] reset_release_ticks;
    } cfg_t;

    typedef struct packed {
        logic       status;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       c2d_drive_enable;
        logic       c2d_level;
        logic       c2ck_drive_enable;
        logic       c2ck_level;
    } res_t;

    // instruction field per request, sent lsb first
    function automatic logic [1:0] ins_code(input logic [2:0] req);
        logic [1:0] code;
        begin
            case (req)
                OP_WAR:  code = 2'd3;
                OP_RAR:  code = 2'd2;
                OP_WDR:  code = 2'd1;
                default: code = 2'd0;
            endcase
            return code;
        end
    endfunction

endpackage

FILE: design/c2ifm_cfg.sv
// apb configuration registers of the c2 interface frame master
module c2ifm_cfg
    import c2ifm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [15:0] wait_timeout_reg;
    logic [15:0] reset_low_reg;
    logic [15:0] reset_release_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_timeout_reg  <= WAIT_TIMEOUT_RST;
            reset_low_reg     <= RESET_LOW_RST;
            reset_release_reg <= RESET_RELEASE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_WAIT_TIMEOUT:  wait_timeout_reg  <= pwdata[15:0];
                REG_RESET_LOW:     reset_low_reg     <= pwdata[15:0];
                REG_RESET_RELEASE: reset_release_reg <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WAIT_TIMEOUT:  prdata = {16'd0, wait_timeout_reg};
            REG_RESET_LOW:     prdata = {16'd0, reset_low_reg};
            REG_RESET_RELEASE: prdata = {16'd0, reset_release_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.wait_timeout_strobes = wait_timeout_reg;
    assign cfg.reset_low_ticks      = reset_low_reg;
    assign cfg.reset_release_ticks  = reset_release_reg;

endmodule

FILE: design/c2ifm_seq.sv
// frame sequencer: state registers and one-tick next-state and pin logic
module c2ifm_seq
    import c2ifm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [2:0] operation,
    input  logic [7:0] data_byte,
    input  logic       c2d_sample,
    input  cfg_t       cfg,
    output res_t       res
);

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  req_reg, req_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic        half_reg, half_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [15:0] reset_count_reg, reset_count_next;
    logic        timeout_reg, timeout_next;

    always_comb
    begin
        logic [1:0] code;
        logic       leave;
        phase_next       = phase_reg;
        req_next         = req_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        half_next        = half_reg;
        wait_count_next  = wait_count_reg;
        reset_count_next = reset_count_reg;
        timeout_next     = timeout_reg;
        res              = '0;
        res.c2ck_level   = 1'b1;
        leave            = 1'b0;

        // request taken only when idle; its tick is the first low tick
        if (phase_reg == PH_IDLE && operation >= OP_WAR && operation <= OP_RST)
        begin
            req_next         = operation;
            shift_next       = (operation == OP_WAR || operation == OP_WDR) ? data_byte : 8'd0;
            bit_count_next   = 4'd0;
            wait_count_next  = 16'd0;
            reset_count_next = 16'd0;
            timeout_next     = 1'b0;
            half_next        = 1'b1;
            phase_next       = (operation == OP_RST) ? PH_RLOW : PH_START;
        end
        code = ins_code(req_next);

        if (phase_next == PH_RLOW || phase_next == PH_RHIGH)
        begin
            res.busy_res          = 1'b1;
            res.c2ck_drive_enable = 1'b1;
            reset_count_next      = reset_count_next + 16'd1;
            if (phase_next == PH_RLOW)
            begin
                res.c2ck_level = 1'b0;
                if (reset_count_next >= cfg.reset_low_ticks)
                begin
                    phase_next       = PH_RHIGH;
                    reset_count_next = 16'd0;
                end
            end
            else if (reset_count_next >= cfg.reset_release_ticks)
            begin
                phase_next       = PH_IDLE;
                reset_count_next = 16'd0;
                half_next        = 1'b0;
                res.done_res     = 1'b1;
            end
        end
        else if (phase_next >= PH_START && phase_next <= PH_STOP)
        begin
            res.busy_res          = 1'b1;
            res.c2ck_drive_enable = 1'b1;
            case (phase_next)
                PH_INS:
                begin
                    res.c2d_drive_enable = 1'b1;
                    res.c2d_level        = code[bit_count_next[0]];
                end
                PH_LENGTH: res.c2d_drive_enable = 1'b1;
                PH_DOUT:
                begin
                    res.c2d_drive_enable = 1'b1;
                    res.c2d_level        = shift_next[0];
                end
                default: ;
            endcase
            if (half_next)
            begin
                res.c2ck_level = 1'b0;
                half_next      = 1'b0;
            end
            else
            begin
                half_next = 1'b1;
                case (phase_next)
                    PH_START:
                    begin
                        phase_next     = PH_INS;
                        bit_count_next = 4'd0;
                    end
                    PH_INS:
                    begin
                        bit_count_next = bit_count_next + 4'd1;
                        if (bit_count_next >= 4'd2)
                        begin
                            bit_count_next = 4'd0;
                            if (req_next == OP_WAR)
                                phase_next = PH_DOUT;
                            else if (req_next == OP_RAR)
                                phase_next = PH_DIN;
                            else
                                phase_next = PH_LENGTH;
                        end
                    end
                    PH_LENGTH:
                    begin
                        bit_count_next = bit_count_next + 4'd1;
                        if (bit_count_next >= 4'd2)
                        begin
                            bit_count_next = 4'd0;
                            if (req_next == OP_WDR)
                                phase_next = PH_DOUT;
                            else
                            begin
                                phase_next      = PH_WAIT;
                                wait_count_next = 16'd0;
                            end
                        end
                    end
                    PH_DOUT:
                    begin
                        shift_next     = {1'b0, shift_next[7:1]};
                        bit_count_next = bit_count_next + 4'd1;
                        if (bit_count_next >= 4'd8)
                        begin
                            bit_count_next = 4'd0;
                            if (req_next == OP_WDR)
                            begin
                                phase_next      = PH_WAIT;
                                wait_count_next = 16'd0;
                            end
                            else
                                phase_next = PH_STOP;
                        end
                    end
                    PH_DIN:
                    begin
                        shift_next     = {c2d_sample, shift_next[7:1]};
                        bit_count_next = bit_count_next + 4'd1;
                        if (bit_count_next >= 4'd8)
                        begin
                            bit_count_next = 4'd0;
                            phase_next     = PH_STOP;
                        end
                    end
                    PH_WAIT:
                    begin
                        if (c2d_sample)
                            leave = 1'b1;
                        else
                        begin
                            if (wait_count_next < WAIT_COUNT_MAX)
                                wait_count_next = wait_count_next + 16'd1;
                            if (wait_count_next >= cfg.wait_timeout_strobes)
                            begin
                                timeout_next = 1'b1;
                                leave        = 1'b1;
                            end
                        end
                        if (leave)
                        begin
                            if (req_next == OP_RDR)
                            begin
                                phase_next     = PH_DIN;
                                shift_next     = 8'd0;
                                bit_count_next = 4'd0;
                            end
                            else
                                phase_next = PH_STOP;
                        end
                    end
                    default:
                    begin
                        res.done_res = 1'b1;
                        if (req_next == OP_RAR || req_next == OP_RDR)
                            res.read_byte = shift_next;
                        if (req_next == OP_WDR || req_next == OP_RDR)
                            res.status = timeout_next;
                        phase_next = PH_IDLE;
                        half_next  = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            phase_next = PH_IDLE;
            half_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            req_reg         <= OP_TICK;
            bit_count_reg   <= 4'd0;
            shift_reg       <= 8'd0;
            half_reg        <= 1'b0;
            wait_count_reg  <= 16'd0;
            reset_count_reg <= 16'd0;
            timeout_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            req_reg         <= req_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            half_reg        <= half_next;
            wait_count_reg  <= wait_count_next;
            reset_count_reg <= reset_count_next;
            timeout_reg     <= timeout_next;
        end
    end

endmodule

FILE: design/c2_interface_frame_master.sv
// top level of the c2 interface frame master
// an input passes the input register and then the result register before its result is shown
// throughput: one item per cycle while the output is not stalled; the frame sequencer advances one tick per item
// a stalled output holds the result register; the input register keeps taking items
// until both are full
// reset: asynchronous, clears sequencer state and valid flags and sets config registers to defaults
module c2_interface_frame_master
    import c2ifm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], c2d_sample[8], zero[15:9]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // c2ck_level, c2ck_drive_enable, c2d_level,
                                   // c2d_drive_enable, busy_res, done_res,
                                   // read_byte[13:6], status[14], zero[15]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       in_valid_reg;
    logic [2:0] in_op_reg;
    logic [7:0] in_data_reg;
    logic       in_sample_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    logic       advance;
    cfg_t       cfg;
    res_t       res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    c2ifm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    c2ifm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .operation  (in_op_reg),
        .data_byte  (in_data_reg),
        .c2d_sample (in_sample_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg     <= s_tuser;
            in_data_reg   <= s_tdata[7:0];
            in_sample_reg <= s_tdata[8];
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};

endmodule

FILE: design/c2ifm_chk.sv
// port-level checker for the c2 interface frame master, bound to the top level
`include "c2_interface_frame_master_defines.svh"

module c2ifm_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `C2IFM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `C2IFM_ASSERT_IMP(a_in_stall, !s_tready, m_tvalid && !m_tready)
    `C2IFM_ASSERT_IMP(a_done_busy, m_tvalid && m_tdata[5], m_tdata[4])
    `C2IFM_ASSERT_IMP(a_idle_quiet, m_tvalid && !m_tdata[5], m_tdata[14:6] == 9'd0)
    `C2IFM_ASSERT_IMP(a_data_needs_clock, m_tvalid && m_tdata[3], m_tdata[1] && m_tdata[4])

endmodule

bind c2_interface_frame_master c2ifm_chk u_c2ifm_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
